// ----- hw/rtl/armv8_integer_execute_unit_core_assert.svh -----
// Assertion macros used by the execute unit core.
`ifndef ARMV8_INTEGER_EXECUTE_UNIT_CORE_ASSERT_SVH
`define ARMV8_INTEGER_EXECUTE_UNIT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define A8IEU_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`define A8IEU_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define A8IEU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define A8IEU_ASSERT_NEVER(lbl, cond, msg)
`define A8IEU_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define A8IEU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/a8ieu_pkg.sv -----
package a8ieu_pkg;

	localparam int XLEN = 64;
	localparam int REG_COUNT = 32;
	localparam int REG_IDX_W = $clog2(REG_COUNT);
	localparam logic [REG_IDX_W-1:0] ZR_IDX = REG_IDX_W'(REG_COUNT - 1);

	localparam logic [5:0] ACT_ADD   = 6'd0;
	localparam logic [5:0] ACT_SUB   = 6'd1;
	localparam logic [5:0] ACT_ADC   = 6'd2;
	localparam logic [5:0] ACT_SBC   = 6'd3;
	localparam logic [5:0] ACT_AND   = 6'd4;
	localparam logic [5:0] ACT_ORR   = 6'd5;
	localparam logic [5:0] ACT_EOR   = 6'd6;
	localparam logic [5:0] ACT_BIC   = 6'd7;
	localparam logic [5:0] ACT_NOT   = 6'd8;
	localparam logic [5:0] ACT_LSL   = 6'd9;
	localparam logic [5:0] ACT_LSR   = 6'd10;
	localparam logic [5:0] ACT_ASR   = 6'd11;
	localparam logic [5:0] ACT_ROR   = 6'd12;
	localparam logic [5:0] ACT_UDIV  = 6'd13;
	localparam logic [5:0] ACT_SDIV  = 6'd14;
	localparam logic [5:0] ACT_MOV   = 6'd15;
	localparam logic [5:0] ACT_MOVK  = 6'd16;
	localparam logic [5:0] ACT_MOVZ  = 6'd17;
	localparam logic [5:0] ACT_CSEL  = 6'd18;
	localparam logic [5:0] ACT_CCMP  = 6'd19;
	localparam logic [5:0] ACT_CCMN  = 6'd20;
	localparam logic [5:0] ACT_RBIT  = 6'd21;
	localparam logic [5:0] ACT_REV16 = 6'd22;
	localparam logic [5:0] ACT_REV32 = 6'd23;
	localparam logic [5:0] ACT_REV64 = 6'd24;
	localparam logic [5:0] ACT_CLZ   = 6'd25;
	localparam logic [5:0] ACT_CLS   = 6'd26;
	localparam logic [5:0] ACT_SBFX  = 6'd27;
	localparam logic [5:0] ACT_UBFX  = 6'd28;
	localparam logic [5:0] ACT_B     = 6'd29;
	localparam logic [5:0] ACT_BCOND = 6'd30;
	localparam logic [5:0] ACT_CBZ   = 6'd31;
	localparam logic [5:0] ACT_CBNZ  = 6'd32;
	localparam logic [5:0] ACT_BR    = 6'd33;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic [XLEN-1:0] res;
		logic            dow;
		logic [3:0]      flags;
		logic            taken;
		logic [XLEN-1:0] tgt;
		logic            div_go;
		logic            div_neg;
		logic [XLEN-1:0] div_a;
		logic [XLEN-1:0] div_b;
	} alu_out_t;

	function automatic logic cond_holds(input logic [3:0] cond, input logic [3:0] f);
		logic r;
		r = 1'b0;
		unique case (cond[3:1])
			3'd0: r = f[2];
			3'd1: r = f[1];
			3'd2: r = f[3];
			3'd3: r = f[0];
			3'd4: r = f[1] & ~f[2];
			3'd5: r = (f[3] == f[0]);
			3'd6: r = (f[3] == f[0]) & ~f[2];
			default: r = 1'b1;
		endcase
		if (cond[3:1] == 3'd7)
			return 1'b1;
		return cond[0] ? ~r : r;
	endfunction

endpackage

// ----- hw/rtl/a8ieu_ram.sv -----
module a8ieu_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re) begin
			rdata0 <= mem_q[raddr0];
			rdata1 <= mem_q[raddr1];
		end
	end

endmodule

// ----- hw/rtl/a8ieu_div.sv -----
module a8ieu_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [a8ieu_pkg::XLEN-1:0] dividend,
	input  logic [a8ieu_pkg::XLEN-1:0] divisor,
	output logic                       busy,
	output logic                       done,
	output logic [a8ieu_pkg::XLEN-1:0] quotient
);
	import a8ieu_pkg::*;

	localparam int CNT_W = $clog2(XLEN);

	logic [XLEN-1:0]  quo_q, rem_q, dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [XLEN:0]    rem_sh, diff;

	assign rem_sh = {rem_q, quo_q[XLEN-1]};
	assign diff = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(XLEN - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[XLEN]) begin
				rem_q <= diff[XLEN-1:0];
				quo_q <= {quo_q[XLEN-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[XLEN-1:0];
				quo_q <= {quo_q[XLEN-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = quo_q;

endmodule

// ----- hw/rtl/a8ieu_alu.sv -----
module a8ieu_alu (
	input  logic [5:0]                 act,
	input  logic                       wide,
	input  logic                       sf,
	input  logic [3:0]                 cond,
	input  logic [5:0]                 pos,
	input  logic [6:0]                 len,
	input  logic [3:0]                 nzcv,
	input  logic [3:0]                 flags_in,
	input  logic [a8ieu_pkg::XLEN-1:0] a_raw,
	input  logic [a8ieu_pkg::XLEN-1:0] b_raw,
	input  logic [a8ieu_pkg::XLEN-1:0] rd_val,
	input  logic [a8ieu_pkg::XLEN-1:0] rn_br,
	input  logic [a8ieu_pkg::XLEN-1:0] imm,
	output a8ieu_pkg::alu_out_t        o
);
	import a8ieu_pkg::*;

	function automatic logic [XLEN-1:0] bswap(input logic [XLEN-1:0] x);
		logic [XLEN-1:0] y;
		for (int i = 0; i < XLEN / 8; i++)
			y[8*i +: 8] = x[XLEN - 8 - 8*i +: 8];
		return y;
	endfunction

	function automatic logic [6:0] clz64(input logic [XLEN-1:0] x);
		logic [6:0] c;
		c = 7'd64;
		for (int i = 0; i < XLEN; i++)
			if (x[i])
				c = 7'(XLEN - 1 - i);
		return c;
	endfunction

	logic [XLEN-1:0]   wm, a, b, y, r, m, f, sa, ma, mb, rv, bs;
	logic [XLEN:0]     sum65;
	logic [32:0]       sum33;
	logic [5:0]        sh;
	logic              cin, cy, ov, hold, nflag, zflag;
	logic [6:0]        lenc;
	logic [2*XLEN-1:0] rr;
	logic [XLEN-1:0]   cls_x;

	always_comb begin
		wm = wide ? '1 : {32'd0, 32'hffffffff};
		a = a_raw & wm;
		b = b_raw & wm;
		sh = wide ? b[5:0] : {1'b0, b[4:0]};
		hold = cond_holds(cond, flags_in);
		lenc = (len > 7'd64) ? 7'd64 : len;
		m = (lenc >= 7'd64) ? '1 : ((64'd1 << lenc[5:0]) - 64'd1);

		y = (act == ACT_SUB || act == ACT_SBC || act == ACT_CCMP) ? (~b & wm) : b;
		cin = (act == ACT_SUB || act == ACT_CCMP) ? 1'b1 :
			((act == ACT_SBC || act == ACT_ADC) ? flags_in[1] : 1'b0);
		sum65 = {1'b0, a} + {1'b0, y} + {64'd0, cin};
		sum33 = {1'b0, a[31:0]} + {1'b0, y[31:0]} + {32'd0, cin};
		if (wide) begin
			r = sum65[XLEN-1:0];
			cy = sum65[XLEN];
			ov = (~(a[63] ^ y[63])) & (a[63] ^ r[63]);
			nflag = r[63];
		end else begin
			r = {32'd0, sum33[31:0]};
			cy = sum33[32];
			ov = (~(a[31] ^ y[31])) & (a[31] ^ r[31]);
			nflag = r[31];
		end
		zflag = (r == '0);

		for (int i = 0; i < XLEN; i++)
			rv[i] = a[XLEN-1-i];
		bs = bswap(a);
		rr = wide ? ({a, a} >> sh) : {64'd0, ({a[31:0], a[31:0]} >> sh)};
		cls_x = ((a >> 1) ^ a) & (wm >> 1);
		f = (a >> pos) & m;
		if (act == ACT_SBFX && lenc >= 7'd1 && lenc < 7'd64 && f[lenc[5:0] - 6'd1])
			f = f | ~m;
		sa = wide ? a : {{32{a[31]}}, a[31:0]};
		ma = (act == ACT_SDIV && sa[63]) ? (64'd0 - sa) : sa;
		if (act == ACT_SDIV) begin
			mb = wide ? b : {{32{b[31]}}, b[31:0]};
			o.div_neg = mb[63] ^ sa[63];
			if (mb[63])
				mb = 64'd0 - mb;
		end else begin
			mb = b;
			o.div_neg = 1'b0;
		end
		if (act != ACT_SDIV)
			ma = a;
		o.div_a = ma;
		o.div_b = mb;
		o.div_go = 1'b0;

		o.res = '0;
		o.dow = 1'b1;
		o.flags = flags_in;
		o.taken = 1'b0;
		o.tgt = '0;

		unique case (act)
			ACT_ADD, ACT_SUB, ACT_ADC, ACT_SBC: begin
				o.res = r;
				if (sf)
					o.flags = {nflag, zflag, cy, ov};
			end
			ACT_AND, ACT_BIC: begin
				o.res = (act == ACT_AND) ? (a & b) : (a & ~b & wm);
				if (sf)
					o.flags = {(wide ? o.res[63] : o.res[31]), (o.res == '0), 2'b00};
			end
			ACT_ORR: o.res = a | b;
			ACT_EOR: o.res = a ^ b;
			ACT_NOT: o.res = ~b & wm;
			ACT_LSL: o.res = (a << sh) & wm;
			ACT_LSR: o.res = a >> sh;
			ACT_ASR: o.res = XLEN'($signed(sa) >>> sh) & wm;
			ACT_ROR: o.res = rr[XLEN-1:0] & wm;
			ACT_UDIV, ACT_SDIV: begin
				o.res = '0;
				o.div_go = (mb != '0);
			end
			ACT_MOV: o.res = b;
			ACT_MOVK: o.res = ((rd_val & ~(m << pos)) | ((b & m) << pos)) & wm;
			ACT_MOVZ: o.res = ((b & m) << pos) & wm;
			ACT_CSEL: o.res = hold ? a : b;
			ACT_CCMP, ACT_CCMN: begin
				o.dow = 1'b0;
				o.flags = hold ? {nflag, zflag, cy, ov} : nzcv;
			end
			ACT_RBIT: o.res = wide ? rv : (rv >> 32);
			ACT_REV16: o.res = ((a & 64'hff00ff00ff00ff00) >> 8) |
				((a & 64'h00ff00ff00ff00ff) << 8);
			ACT_REV32: o.res = {bs[31:0], bs[63:32]} & wm;
			ACT_REV64: o.res = wide ? bs : (bs >> 32);
			ACT_CLZ: o.res = {57'd0, (wide ? clz64(a) : clz64({a[31:0], 32'hffffffff}))};
			ACT_CLS: o.res = {57'd0, (wide ? clz64({cls_x[62:0], 1'b1}) :
				clz64({cls_x[30:0], 33'h1ffffffff}))};
			ACT_SBFX, ACT_UBFX: o.res = f & wm;
			ACT_B: begin
				o.dow = 1'b0;
				o.taken = 1'b1;
			end
			ACT_BCOND: begin
				o.dow = 1'b0;
				o.taken = hold;
			end
			ACT_CBZ: begin
				o.dow = 1'b0;
				o.taken = (a == '0);
			end
			ACT_CBNZ: begin
				o.dow = 1'b0;
				o.taken = (a != '0);
			end
			ACT_BR: begin
				o.dow = 1'b0;
				o.taken = 1'b1;
			end
			default: o.dow = 1'b0;
		endcase
		o.res = o.res & wm;
		if (o.taken)
			o.tgt = (act == ACT_BR) ? rn_br : imm;
	end

endmodule

// ----- hw/rtl/armv8_integer_execute_unit_core.sv -----
// Executes one decoded AArch64 integer operation per request against a 32-entry register
// file held in a synchronous RAM, a stack pointer and the NZCV flags. A request is read from
// the RAM in the cycle it is accepted, computed in the next (EXEC), and committed from the
// COMMIT state once the output register can take it. UDIV and SDIV with a nonzero divisor
// run through a one-bit-per-cycle divider in the DIV state between EXEC and COMMIT. The
// result waits in an output register; the next request is taken once the previous result
// has been committed to that register.
module armv8_integer_execute_unit_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [5:0]  action,
	input  logic [4:0]  dest_reg,
	input  logic [4:0]  src_a_reg,
	input  logic [4:0]  src_b_reg,
	input  logic [63:0] immediate,
	input  logic        use_immediate,
	input  logic        set_flags,
	input  logic        wide,
	input  logic [3:0]  cond_code,
	input  logic [5:0]  bit_pos,
	input  logic [6:0]  bit_len,
	input  logic [3:0]  nzcv_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        write_enable,
	output logic [4:0]  write_reg,
	output logic [63:0] write_value,
	output logic [3:0]  flags_out,
	output logic        branch_taken,
	output logic [63:0] branch_target
);
	import a8ieu_pkg::*;
`include "armv8_integer_execute_unit_core_assert.svh"

	state_t state_q, state_d;

	logic [5:0]           act_q;
	logic [REG_IDX_W-1:0] rd_q, ra_q, rb_q, idx0_q;
	logic [XLEN-1:0]      imm_q;
	logic                 useimm_q, sf_q, wide_q;
	logic [3:0]           cond_q, nzcv_q;
	logic [5:0]           pos_q;
	logic [6:0]           len_q;

	logic [XLEN-1:0]      sp_q;
	logic [3:0]           flags_q;
	logic [REG_COUNT-1:0] vld_q;

	logic                 accept, commit_go, sp_ar, sp_dst, wide_mask_sel;
	logic                 rf_we;
	logic [REG_IDX_W-1:0] raddr0;
	logic [XLEN-1:0]      rdata0, rdata1, rf0, rf1, a_raw, b_raw, rn_br, div_q, div_fix;
	logic                 div_start, div_busy, div_done;
	alu_out_t             alu_o, rslt_q;

	logic                 out_valid_q, we_q, taken_q;
	logic [4:0]           wreg_q;
	logic [XLEN-1:0]      wval_q, tgt_q;
	logic [3:0]           fout_q;

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign raddr0 = (action == ACT_MOVK) ? dest_reg : src_a_reg;

	a8ieu_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rd_q),
		.wdata (rslt_q.res),
		.re    (accept),
		.raddr0(raddr0),
		.raddr1(src_b_reg),
		.rdata0(rdata0),
		.rdata1(rdata1)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			rd_q <= dest_reg;
			ra_q <= src_a_reg;
			rb_q <= src_b_reg;
			idx0_q <= raddr0;
			imm_q <= immediate;
			useimm_q <= use_immediate;
			sf_q <= set_flags;
			wide_q <= wide;
			cond_q <= cond_code;
			pos_q <= bit_pos;
			len_q <= bit_len;
			nzcv_q <= nzcv_value;
		end
	end

	assign rf0 = (idx0_q == ZR_IDX || !vld_q[idx0_q]) ? '0 : rdata0;
	assign rf1 = (rb_q == ZR_IDX || !vld_q[rb_q]) ? '0 : rdata1;
	assign sp_ar = (act_q == ACT_ADD || act_q == ACT_SUB) && useimm_q && !sf_q;
	assign sp_dst = sp_ar ||
		((act_q == ACT_AND || act_q == ACT_ORR || act_q == ACT_EOR) && useimm_q && !sf_q);
	assign a_raw = (ra_q == ZR_IDX) ? (sp_ar ? sp_q : '0) : rf0;
	assign rn_br = (ra_q == ZR_IDX) ? '0 : rf0;
	assign b_raw = useimm_q ? imm_q : rf1;

	a8ieu_alu u_alu (
		.act     (act_q),
		.wide    (wide_q),
		.sf      (sf_q),
		.cond    (cond_q),
		.pos     (pos_q),
		.len     (len_q),
		.nzcv    (nzcv_q),
		.flags_in(flags_q),
		.a_raw   (a_raw),
		.b_raw   (b_raw),
		.rd_val  (rf0),
		.rn_br   (rn_br),
		.imm     (imm_q),
		.o       (alu_o)
	);

	assign div_start = (state_q == ST_EXEC) && alu_o.div_go;

	a8ieu_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(alu_o.div_a),
		.divisor (alu_o.div_b),
		.busy    (div_busy),
		.done    (div_done),
		.quotient(div_q)
	);

	assign wide_mask_sel = wide_q;
	assign div_fix = (rslt_q.div_neg ? (64'd0 - div_q) : div_q) &
		(wide_mask_sel ? '1 : {32'd0, 32'hffffffff});

	assign commit_go = (state_q == ST_COMMIT) && (!out_valid_q || !out_stall);
	assign rf_we = commit_go && rslt_q.dow && (rd_q != ZR_IDX);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = ST_EXEC;
			end
			ST_EXEC: state_d = alu_o.div_go ? ST_DIV : ST_COMMIT;
			ST_DIV: begin
				if (div_done)
					state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (commit_go)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC)
			rslt_q <= alu_o;
		else if (state_q == ST_DIV && div_done)
			rslt_q.res <= div_fix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
			flags_q <= '0;
			vld_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (commit_go) begin
				out_valid_q <= 1'b1;
				flags_q <= rslt_q.flags;
				if (rf_we)
					vld_q[rd_q] <= 1'b1;
				if (rslt_q.dow && rd_q == ZR_IDX && sp_dst)
					sp_q <= rslt_q.res;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit_go) begin
			we_q <= rslt_q.dow && (rd_q != ZR_IDX || sp_dst);
			wreg_q <= (rslt_q.dow && (rd_q != ZR_IDX || sp_dst)) ? rd_q : '0;
			wval_q <= (rslt_q.dow && (rd_q != ZR_IDX || sp_dst)) ? rslt_q.res : '0;
			fout_q <= rslt_q.flags;
			taken_q <= rslt_q.taken;
			tgt_q <= rslt_q.tgt;
		end
	end

	assign out_valid = out_valid_q;
	assign write_enable = we_q;
	assign write_reg = wreg_q;
	assign write_value = wval_q;
	assign flags_out = fout_q;
	assign branch_taken = taken_q;
	assign branch_target = tgt_q;

	`A8IEU_ASSERT_NEVER(a_rf_we_zr, rf_we && rd_q == ZR_IDX, "register 31 written to the RAM")
	`A8IEU_ASSERT_IMPLIES(a_div_state, div_busy, state_q == ST_DIV, "divider busy outside DIV")
	`A8IEU_ASSERT_NEXT(a_commit_out, commit_go, out_valid, "commit did not raise out_valid")
	`A8IEU_ASSERT_NEVER(a_accept_busy, accept && out_valid_q && state_q != ST_IDLE,
		"request accepted while busy")

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
	import a8ieu_pkg::*;

	typedef struct {
		logic [5:0]  action;
		logic [4:0]  dest_reg;
		logic [4:0]  src_a_reg;
		logic [4:0]  src_b_reg;
		logic [63:0] immediate;
		logic        use_immediate;
		logic        set_flags;
		logic        wide;
		logic [3:0]  cond_code;
		logic [5:0]  bit_pos;
		logic [6:0]  bit_len;
		logic [3:0]  nzcv_value;
	} op_req_t;

	typedef struct {
		logic        write_enable;
		logic [4:0]  write_reg;
		logic [63:0] write_value;
		logic [3:0]  flags_out;
		logic        branch_taken;
		logic [63:0] branch_target;
	} op_res_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [5:0] action;
	logic [4:0] dest_reg;
	logic [4:0] src_a_reg;
	logic [4:0] src_b_reg;
	logic [63:0] immediate;
	logic use_immediate;
	logic set_flags;
	logic wide;
	logic [3:0] cond_code;
	logic [5:0] bit_pos;
	logic [6:0] bit_len;
	logic [3:0] nzcv_value;
	logic out_valid;
	logic out_stall;
	logic write_enable;
	logic [4:0] write_reg;
	logic [63:0] write_value;
	logic [3:0] flags_out;
	logic branch_taken;
	logic [63:0] branch_target;

	armv8_integer_execute_unit_core dut (.*);

	op_req_t pending_reqs[$];
	op_res_t expected_results[$];
	logic [63:0] gpr[32];
	logic [63:0] sp_value;
	logic [3:0] nzcv;
	int mismatches = 0;
	int accepted = 0;
	bit stim_done = 0;
	bit hold_sender = 0;
	int long_hold = 0;
	int burst_left = 0;
	int gap_left = 0;
	longint cycles = 0;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] read_gpr(logic [4:0] idx, bit with_sp);
		if (idx == 5'd31)
			return with_sp ? sp_value : 64'd0;
		return gpr[idx];
	endfunction

	function automatic bit check_cond(logic [3:0] c);
		bit r;
		case (c[3:1])
			3'd0: r = nzcv[2];
			3'd1: r = nzcv[1];
			3'd2: r = nzcv[3];
			3'd3: r = nzcv[0];
			3'd4: r = nzcv[1] && !nzcv[2];
			3'd5: r = nzcv[3] == nzcv[0];
			3'd6: r = (nzcv[3] == nzcv[0]) && !nzcv[2];
			default: return 1'b1;
		endcase
		return c[0] ? !r : r;
	endfunction

	function automatic logic [63:0] add_with_flags(logic [63:0] x, logic [63:0] y, bit cin,
			bit w64, output logic [3:0] fl);
		logic [64:0] s;
		logic [32:0] s32;
		logic [63:0] r;
		bit n, c, v;
		if (w64) begin
			s = {1'b0, x} + {1'b0, y} + cin;
			r = s[63:0];
			c = s[64];
			n = r[63];
			v = (x[63] == y[63]) && (r[63] != x[63]);
		end else begin
			s32 = {1'b0, x[31:0]} + {1'b0, y[31:0]} + cin;
			r = {32'd0, s32[31:0]};
			c = s32[32];
			n = r[31];
			v = (x[31] == y[31]) && (r[31] != x[31]);
		end
		fl = {n, r == 0, c, v};
		return r;
	endfunction

	function automatic op_res_t execute_op(op_req_t q);
		op_res_t o;
		logic [63:0] wm, a, b, res, m, y, f;
		logic [3:0] fl;
		int w, sh, len, i;
		bit sp_ar, sp_dst, dow, taken, na, nb;
		logic [63:0] sa, sb, ma, mb, qt;
		wm = q.wide ? '1 : 64'hffffffff;
		w = q.wide ? 64 : 32;
		sp_ar = (q.action <= ACT_SUB) && q.use_immediate && !q.set_flags;
		sp_dst = sp_ar || (q.action >= ACT_AND && q.action <= ACT_EOR && q.use_immediate
			&& !q.set_flags);
		a = read_gpr(q.src_a_reg, sp_ar) & wm;
		b = (q.use_immediate ? q.immediate : read_gpr(q.src_b_reg, 0)) & wm;
		sh = int'(b & 64'(w - 1));
		len = q.bit_len > 64 ? 64 : int'(q.bit_len);
		m = len >= 64 ? '1 : ((64'd1 << len) - 1);
		res = 0;
		dow = 1;
		taken = 0;
		case (q.action)
			ACT_ADD, ACT_SUB, ACT_ADC, ACT_SBC: begin
				y = q.action[0] ? (~b & wm) : b;
				res = add_with_flags(a, y, q.action == ACT_SUB ? 1'b1 :
					(q.action == ACT_ADD ? 1'b0 : nzcv[1]), q.wide, fl);
				if (q.set_flags)
					nzcv = fl;
			end
			ACT_AND, ACT_BIC: begin
				res = q.action == ACT_AND ? (a & b) : (a & ~b & wm);
				if (q.set_flags)
					nzcv = {res[w-1], res == 0, 2'b00};
			end
			ACT_ORR: res = a | b;
			ACT_EOR: res = a ^ b;
			ACT_NOT: res = ~b & wm;
			ACT_LSL: res = (a << sh) & wm;
			ACT_LSR: res = a >> sh;
			ACT_ASR: begin
				res = a >> sh;
				if (sh != 0 && a[w-1])
					res |= wm & ~(wm >> sh);
			end
			ACT_ROR: res = sh != 0 ? (((a >> sh) | (a << (w - sh))) & wm) : a;
			ACT_UDIV: res = b != 0 ? a / b : 0;
			ACT_SDIV: begin
				sa = q.wide ? a : {{32{a[31]}}, a[31:0]};
				sb = q.wide ? b : {{32{b[31]}}, b[31:0]};
				na = sa[63];
				nb = sb[63];
				ma = na ? -sa : sa;
				mb = nb ? -sb : sb;
				if (mb == 0)
					res = 0;
				else begin
					qt = ma / mb;
					res = ((na != nb) ? -qt : qt) & wm;
				end
			end
			ACT_MOV: res = b;
			ACT_MOVK: res = ((read_gpr(q.dest_reg, 0) & ~(m << q.bit_pos))
				| ((b & m) << q.bit_pos)) & wm;
			ACT_MOVZ: res = ((b & m) << q.bit_pos) & wm;
			ACT_CSEL: res = check_cond(q.cond_code) ? a : b;
			ACT_CCMP, ACT_CCMN: begin
				dow = 0;
				if (check_cond(q.cond_code)) begin
					void'(add_with_flags(a, q.action == ACT_CCMP ? (~b & wm) : b,
						q.action == ACT_CCMP, q.wide, fl));
					nzcv = fl;
				end else
					nzcv = q.nzcv_value;
			end
			ACT_RBIT: begin
				for (i = 0; i < w; i++)
					res[i] = a[w-1-i];
			end
			ACT_REV16: begin
				for (i = 0; i < 8; i += 2) begin
					res[i*8 +: 8] = a[(i+1)*8 +: 8];
					res[(i+1)*8 +: 8] = a[i*8 +: 8];
				end
			end
			ACT_REV32: begin
				for (i = 0; i < 8; i++)
					res[i*8 +: 8] = a[((i/4)*4 + 3 - i%4)*8 +: 8];
				res &= wm;
			end
			ACT_REV64: begin
				for (i = 0; i < w / 8; i++)
					res[i*8 +: 8] = a[(w/8 - 1 - i)*8 +: 8];
			end
			ACT_CLZ: begin
				for (i = w - 1; i >= 0 && !a[i]; i--)
					res++;
			end
			ACT_CLS: begin
				y = ((a >> 1) ^ a) & (wm >> 1);
				for (i = w - 2; i >= 0 && !y[i]; i--)
					res++;
			end
			ACT_SBFX, ACT_UBFX: begin
				f = (a >> q.bit_pos) & m;
				if (q.action == ACT_SBFX && len >= 1 && len < 64 && f[len-1])
					f |= ~m;
				res = f & wm;
			end
			ACT_B, ACT_BR: begin
				dow = 0;
				taken = 1;
			end
			ACT_BCOND: begin
				dow = 0;
				taken = check_cond(q.cond_code);
			end
			ACT_CBZ: begin
				dow = 0;
				taken = a == 0;
			end
			ACT_CBNZ: begin
				dow = 0;
				taken = a != 0;
			end
			default: dow = 0;
		endcase
		o = '{default: 0};
		if (taken)
			o.branch_target = q.action == ACT_BR ? read_gpr(q.src_a_reg, 0) : q.immediate;
		o.branch_taken = taken;
		if (dow) begin
			res &= wm;
			if (q.dest_reg == 5'd31) begin
				if (sp_dst) begin
					sp_value = res;
					o.write_enable = 1'b1;
					o.write_reg = 5'd31;
					o.write_value = res;
				end
			end else begin
				gpr[q.dest_reg] = res;
				o.write_enable = 1'b1;
				o.write_reg = q.dest_reg;
				o.write_value = res;
			end
		end
		o.flags_out = nzcv;
		return o;
	endfunction

	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return '1;
			2: return 64'h8000000000000000;
			3: return 64'h7fffffff;
			4: return 64'h80000000;
			5: return 64'($urandom_range(0, 70));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic op_req_t random_op();
		op_req_t q;
		q.action = $urandom_range(0, 19) == 0 ? 6'($urandom_range(34, 63))
			: 6'($urandom_range(0, 33));
		q.dest_reg = $urandom_range(0, 7) == 0 ? 5'd31 : 5'($urandom);
		q.src_a_reg = $urandom_range(0, 7) == 0 ? 5'd31 : 5'($urandom);
		q.src_b_reg = $urandom_range(0, 7) == 0 ? 5'd31 : 5'($urandom);
		q.immediate = pick_value();
		q.use_immediate = 1'($urandom);
		q.set_flags = 1'($urandom);
		q.wide = 1'($urandom);
		q.cond_code = 4'($urandom);
		q.bit_pos = 6'($urandom);
		q.bit_len = $urandom_range(0, 9) == 0 ? 7'($urandom) : 7'($urandom_range(1, 64));
		q.nzcv_value = 4'($urandom);
		return q;
	endfunction

	task automatic push_op(logic [5:0] act, logic [4:0] rd, logic [4:0] rn, logic [4:0] rm,
			logic [63:0] imm, bit ui, bit sf, bit w64);
		op_req_t q;
		q = random_op();
		q.action = act;
		q.dest_reg = rd;
		q.src_a_reg = rn;
		q.src_b_reg = rm;
		q.immediate = imm;
		q.use_immediate = ui;
		q.set_flags = sf;
		q.wide = w64;
		pending_reqs.push_back(q);
	endtask

	initial begin
		op_req_t q;
		int i;
		for (i = 0; i < 32; i++)
			gpr[i] = 0;
		sp_value = 0;
		nzcv = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		push_op(ACT_ADD, 5'd31, 5'd31, 5'd0, 64'h1000, 1, 0, 1);
		push_op(ACT_ADD, 5'd1, 5'd31, 5'd0, '1, 1, 1, 1);
		push_op(ACT_SUB, 5'd2, 5'd1, 5'd0, 64'h8000000000000000, 1, 1, 1);
		push_op(ACT_ADC, 5'd3, 5'd2, 5'd1, 0, 0, 1, 0);
		push_op(ACT_SBC, 5'd4, 5'd3, 5'd2, 64'h7fffffff, 1, 1, 0);
		push_op(ACT_MOV, 5'd5, 5'd0, 5'd0, 64'h8000000000000000, 1, 0, 1);
		push_op(ACT_MOV, 5'd6, 5'd0, 5'd0, '1, 1, 0, 1);
		push_op(ACT_SDIV, 5'd7, 5'd5, 5'd6, 0, 0, 0, 1);
		push_op(ACT_SDIV, 5'd8, 5'd5, 5'd6, 64'h80000000, 0, 0, 0);
		push_op(ACT_UDIV, 5'd9, 5'd6, 5'd0, 0, 0, 0, 1);
		push_op(ACT_EOR, 5'd31, 5'd6, 5'd0, 64'h5a5a, 1, 0, 1);
		push_op(ACT_AND, 5'd10, 5'd6, 5'd0, 0, 1, 1, 0);
		push_op(ACT_ROR, 5'd11, 5'd6, 5'd0, 64'd33, 1, 0, 0);
		push_op(ACT_CLS, 5'd12, 5'd5, 5'd0, 0, 0, 0, 1);
		push_op(ACT_CLZ, 5'd13, 5'd31, 5'd0, 0, 0, 0, 0);
		push_op(ACT_BR, 5'd0, 5'd6, 5'd0, 0, 0, 0, 1);
		push_op(ACT_CBZ, 5'd0, 5'd31, 5'd0, 64'h40, 0, 0, 1);
		for (i = 30; i < 34; i++) begin
			q = random_op();
			q.action = 6'(i);
			pending_reqs.push_back(q);
		end
		for (i = 0; i < 1850; i++) begin
			if (i == 900) begin
				wait (pending_reqs.size() == 0);
				hold_sender = 1;
				wait (expected_results.size() == 0);
				hold_sender = 0;
			end
			q = random_op();
			if ((q.action == ACT_UDIV || q.action == ACT_SDIV) && $urandom_range(0, 3) != 0)
				q.action = ACT_ORR;
			pending_reqs.push_back(q);
			if (pending_reqs.size() > 40)
				wait (pending_reqs.size() < 20);
		end
		wait (pending_reqs.size() == 0 && !in_valid);
		stim_done = 1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			action <= 0;
			dest_reg <= 0;
			src_a_reg <= 0;
			src_b_reg <= 0;
			immediate <= 0;
			use_immediate <= 0;
			set_flags <= 0;
			wide <= 0;
			cond_code <= 0;
			bit_pos <= 0;
			bit_len <= 0;
			nzcv_value <= 0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				expected_results.push_back(execute_op(pending_reqs.pop_front()));
				accepted++;
			end
			if (gap_left > 0)
				gap_left--;
			else if (burst_left == 0) begin
				burst_left = $urandom_range(1, 30);
				gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
			end
			if (pending_reqs.size() > 0 && gap_left == 0 && burst_left > 0 && !hold_sender)
					begin
				burst_left--;
				in_valid <= 1;
				action <= pending_reqs[0].action;
				dest_reg <= pending_reqs[0].dest_reg;
				src_a_reg <= pending_reqs[0].src_a_reg;
				src_b_reg <= pending_reqs[0].src_b_reg;
				immediate <= pending_reqs[0].immediate;
				use_immediate <= pending_reqs[0].use_immediate;
				set_flags <= pending_reqs[0].set_flags;
				wide <= pending_reqs[0].wide;
				cond_code <= pending_reqs[0].cond_code;
				bit_pos <= pending_reqs[0].bit_pos;
				bit_len <= pending_reqs[0].bit_len;
				nzcv_value <= pending_reqs[0].nzcv_value;
			end else
				in_valid <= 0;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 0;
		else if (accepted >= 300 && accepted < 305 && long_hold == 0) begin
			long_hold <= 1;
			out_stall <= 1;
		end else if (long_hold > 0 && long_hold < 400) begin
			long_hold <= long_hold + 1;
			out_stall <= 1;
		end else if (cycles % 2000 < 500)
			out_stall <= 0;
		else
			out_stall <= $urandom_range(0, 2) == 0;
	end

	always @(posedge clk) begin
		op_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: reg %0d value %h", write_reg, write_value);
			end else begin
				e = expected_results.pop_front();
				if (e.write_enable !== write_enable || e.write_reg !== write_reg
						|| e.write_value !== write_value || e.flags_out !== flags_out
						|| e.branch_taken !== branch_taken
						|| e.branch_target !== branch_target) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp we %b reg %0d val %h nzcv %h br %b tgt %h; got we %b reg %0d val %h nzcv %h br %b tgt %h",
							e.write_enable, e.write_reg, e.write_value, e.flags_out,
							e.branch_taken, e.branch_target, write_enable, write_reg,
							write_value, flags_out, branch_taken, branch_target);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1000000) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		wait (stim_done && expected_results.size() == 0);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
